// ===== design/keyboard_biphase_serial_link_defines.svh =====
// Assertion macros for the keyboard biphase serial link checker
`ifndef KEYBOARD_BIPHASE_SERIAL_LINK_DEFINES_SVH
`define KEYBOARD_BIPHASE_SERIAL_LINK_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define KBSL_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("keyboard link check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define KBSL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("keyboard link check failed");

`endif

// ===== design/kbsl_pkg.sv =====
// Package with constants, types and the frame builder of the keyboard serial link
`timescale 1ns / 1ps

package kbsl_pkg;

    localparam int QUEUE_DEPTH     = 16;
    localparam int FRAME_HALF_BITS = 42;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(FRAME_HALF_BITS + 1);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [7:0] PORT_LATCH_A = 8'h60;
    localparam logic [7:0] PORT_LATCH_B = 8'h61;
    localparam logic [7:0] PORT_STATUS  = 8'h62;
    localparam logic [7:0] PORT_NMI     = 8'ha0;

    localparam logic [7:0] RD_UNKNOWN    = 8'hff;
    localparam logic [7:0] STAT_ALWAYS   = 8'h02;
    localparam logic [7:0] STAT_LATCH    = 8'h01;
    localparam logic [7:0] STAT_SPEAKER  = 8'h30;
    localparam logic [7:0] STAT_LINE     = 8'h40;

    typedef struct packed {
        logic [7:0] read_data;
        logic       line_level;
        logic       nmi_enable;
        logic       key_dropped;
    } res_t;

    function automatic logic [FRAME_HALF_BITS-1:0] build_frame(input logic [7:0] code);
        logic [FRAME_HALF_BITS-1:0] f;
        logic                       par;
        f      = '0;
        par    = 1'b0;
        f[0]   = 1'b1;
        for (int c = 0; c < 8; c++)
        begin
            par = par ^ code[c];
            if (code[c])
            begin
                f[2 * (c + 1)] = 1'b1;
            end
            else
            begin
                f[2 * (c + 1) + 1] = 1'b1;
            end
        end
        if (par)
        begin
            f[18] = 1'b1;
        end
        else
        begin
            f[19] = 1'b1;
        end
        return f;
    endfunction

endpackage

// ===== design/keyboard_biphase_serial_link.sv =====
// Top level of the keyboard biphase serial link with key queue and port interface
// A result is registered after its item transfer, in the output register or, under stall, in the skid stage.
// Throughput: one item per cycle while the skid stage is empty; an output register and a skid stage part the channels.
// The key queue is a synchronous memory, one write and one registered read per cycle.
// A dequeued code is read out in the dequeue cycle and loaded into the frame in the cycle after.
// Reset clears pointers, fill count, frame index, latches and output valid flags; queue contents are
// undefined until written and need no clearing pass.
`timescale 1ns / 1ps

module keyboard_biphase_serial_link
    import kbsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic [7:0] port,
    input  logic       speaker_on,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] read_data,
    output logic       line_level,
    output logic       nmi_enable,
    output logic       key_dropped
);

    logic [7:0]                 key_mem [QUEUE_DEPTH];
    logic [7:0]                 rdata_reg;
    logic                       load_reg;
    logic [FRAME_HALF_BITS-1:0] frame_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             latch_reg, latch_next;
    logic             line_reg, line_next;
    logic [7:0]       port_a_reg, port_a_next;
    logic [7:0]       port_b_reg, port_b_next;
    logic             mask_reg, mask_next;

    logic       out_valid_reg, skid_valid_reg;
    res_t       out_reg, skid_reg;
    res_t       res;

    logic                       fire;
    logic                       deq;
    logic                       push;
    logic                       full;
    logic [IDX_W-1:0]           idx_eff;
    logic [IDX_W-1:0]           pos;
    logic [FRAME_HALF_BITS-1:0] frame_src;
    cmd_t                       cmd_c;

    assign cmd_c      = cmd_t'(cmd);
    assign fire       = item_valid && !item_stall;
    assign item_stall = skid_valid_reg;
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign deq        = fire && (cmd_c == CMD_TICK) && (count_reg != '0)
                        && (idx_reg == '0) && !latch_reg;
    assign push       = fire && (cmd_c == CMD_ADD) && !full;
    assign frame_src  = load_reg ? build_frame(rdata_reg) : frame_reg;
    assign idx_eff    = deq ? IDX_W'(1) : idx_reg;
    assign pos        = idx_eff - IDX_W'(1);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        latch_next  = latch_reg;
        line_next   = line_reg;
        port_a_next = port_a_reg;
        port_b_next = port_b_reg;
        mask_next   = mask_reg;
        res         = '0;

        if (deq)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
            latch_next = 1'b1;
        end
        if (push)
        begin
            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end

        if (fire)
        begin
            case (cmd_c)
                CMD_TICK:
                begin
                    if (idx_eff != '0)
                    begin
                        line_next = deq ? 1'b1 : frame_src[pos];
                        idx_next  = (idx_eff == IDX_W'(FRAME_HALF_BITS)) ? '0
                                    : idx_eff + IDX_W'(1);
                    end
                end
                CMD_ADD:
                begin
                    res.key_dropped = full;
                end
                CMD_WRITE:
                begin
                    case (port)
                        PORT_LATCH_A: port_a_next = data_byte;
                        PORT_LATCH_B: port_b_next = data_byte;
                        PORT_NMI:     mask_next   = data_byte[7];
                        default:      ;
                    endcase
                end
                CMD_READ:
                begin
                    case (port)
                        PORT_LATCH_A: res.read_data = port_a_reg;
                        PORT_LATCH_B: res.read_data = port_b_reg;
                        PORT_STATUS:
                        begin
                            res.read_data = STAT_ALWAYS
                                | (latch_reg  ? STAT_LATCH   : 8'h00)
                                | (speaker_on ? STAT_SPEAKER : 8'h00)
                                | (line_reg   ? STAT_LINE    : 8'h00);
                        end
                        PORT_NMI:
                        begin
                            latch_next    = 1'b0;
                            res.read_data = 8'h00;
                        end
                        default:      res.read_data = RD_UNKNOWN;
                    endcase
                end
                default: ;
            endcase
        end

        res.line_level = line_next;
        res.nmi_enable = mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            key_mem[tail_reg] <= data_byte;
        end
        if (deq)
        begin
            rdata_reg <= key_mem[head_reg];
        end
        if (load_reg)
        begin
            frame_reg <= frame_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            latch_reg  <= 1'b0;
            line_reg   <= 1'b0;
            port_a_reg <= '0;
            port_b_reg <= '0;
            mask_reg   <= 1'b0;
            load_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            latch_reg  <= latch_next;
            line_reg   <= line_next;
            port_a_reg <= port_a_next;
            port_b_reg <= port_b_next;
            mask_reg   <= mask_next;
            load_reg   <= deq;
        end
    end

    // hold results in the output register, park one in the skid stage under stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (out_valid_reg && result_stall)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && !result_stall)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (out_valid_reg && result_stall)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (out_valid_reg && !result_stall && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign read_data    = out_reg.read_data;
    assign line_level   = out_reg.line_level;
    assign nmi_enable   = out_reg.nmi_enable;
    assign key_dropped  = out_reg.key_dropped;

endmodule

// ===== design/kbsl_checker.sv =====
// Port checker for the keyboard biphase serial link and its bind
`timescale 1ns / 1ps
`include "keyboard_biphase_serial_link_defines.svh"

module kbsl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic [1:0] cmd,
    input logic [7:0] data_byte,
    input logic [7:0] port,
    input logic       speaker_on,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] read_data,
    input logic       line_level,
    input logic       nmi_enable,
    input logic       key_dropped
);

    `KBSL_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
    `KBSL_ASSERT_NOW(a_drop_no_data, result_valid && key_dropped, read_data == 8'h00)
    `KBSL_ASSERT_NEXT(a_empty_out_fills, item_valid && !item_stall && !result_valid, result_valid)
    `KBSL_ASSERT_NOW(a_stall_needs_result, item_stall, result_valid)

endmodule

bind keyboard_biphase_serial_link kbsl_checker u_kbsl_checker (.*);
